// ===== hdl/lzss_pkg.sv =====
// Shared constants and types for the LZSS decompressor.
package lzss_pkg;

	localparam int WINDOW_BYTES = 4096;
	localparam int WIN_AW = $clog2(WINDOW_BYTES);
	localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(12'hfee);
	localparam logic [3:0] FLAG_BITS = 4'd8;
	localparam logic [4:0] MATCH_EXTRA = 5'd2;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_ITEM,
		PH_MATCH_HI
	} phase_t;

endpackage

// ===== hdl/lzss_decompressor.sv =====
// LZSS decompressor with a 4096-byte ring window and a one-byte-per-step sequencer.
// Each request is one input byte: a flag byte, the first byte of a match, a literal, which
// passes S_DECODE and S_EMIT into the output register, or the second byte of a match, which
// emits 3..18 bytes with one window read and one emit/write step per byte on the single port.
// A full output register that is stalled holds the emit step. One request is in work at a
// time and in_stall is high until it is done. Reset (arst_n low) clears parser, counters and
// output_length and sets the write position to 0xfee; the window needs no clearing pass.
module lzss_decompressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        new_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        stream_done,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data
);

	// Sequencer states. DECODE interprets the latched byte; READ issues the window
	// read of one match byte; EMIT loads the output register and writes the window.
	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_EMIT
	} state_t;

	state_t                          state_q;
	lzss_pkg::phase_t                phase_q;
	logic [7:0]                      byte_q;
	logic [7:0]                      ctrl_q;
	logic [3:0]                      bits_q;
	logic [7:0]                      pend_q;
	logic [31:0]                     emitted_q;
	logic                            finished_q;
	logic [31:0]                     out_len_q;
	logic [lzss_pkg::WIN_AW-1:0]     wpos_q;
	logic [lzss_pkg::WIN_AW:0]       fill_q;
	logic [lzss_pkg::WIN_AW-1:0]     src_q;
	logic [4:0]                      len_left_q;
	logic                            lit_q;
	logic                            src_valid_q;
	logic [7:0]                      rd_data_q;
	logic                            out_valid_q;
	logic [7:0]                      out_byte_q;
	logic                            out_last_q;
	logic                            out_done_q;

	// The window, one byte per entry, with no reset.
	logic [7:0] win_mem [lzss_pkg::WINDOW_BYTES];

	logic                        in_take;
	logic                        out_free;
	logic [31:0]                 emit_cnt;
	logic                        emit_done;
	logic                        emit_last;
	logic [7:0]                  emit_data;
	logic                        emit_fire;
	logic                        mem_we;
	logic [lzss_pkg::WIN_AW-1:0] src_dist;
	logic                        src_written;
	logic [3:0]                  bits_next;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The window is written strictly in order from the start position after a restart,
	// so an entry has been written since then exactly when its distance from the start
	// position is below the fill count. Unwritten entries read as zero.
	assign src_dist    = src_q - lzss_pkg::START_POS;
	assign src_written = ({1'b0, src_dist} < fill_q);

	assign emit_cnt  = emitted_q + 32'd1;
	assign emit_done = (emit_cnt == out_len_q);
	assign emit_data = lit_q ? byte_q : (src_valid_q ? rd_data_q : 8'd0);
	assign emit_last = emit_done || lit_q || (len_left_q == 5'd0);
	assign emit_fire = (state_q == S_EMIT) && out_free;
	assign mem_we    = emit_fire && !emit_done;

	// Each used control bit shifts out; the phase returns to flag once all are spent.
	assign bits_next = (bits_q != 4'd0) ? bits_q - 4'd1 : 4'd0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[wpos_q] <= emit_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_data_q <= win_mem[src_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= lzss_pkg::PH_FLAG;
			byte_q      <= 8'd0;
			ctrl_q      <= 8'd0;
			bits_q      <= 4'd0;
			pend_q      <= 8'd0;
			emitted_q   <= 32'd0;
			finished_q  <= 1'b0;
			out_len_q   <= 32'd0;
			wpos_q      <= lzss_pkg::START_POS;
			fill_q      <= '0;
			src_q       <= '0;
			len_left_q  <= 5'd0;
			lit_q       <= 1'b0;
			src_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= 8'd0;
			out_last_q  <= 1'b0;
			out_done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				out_len_q <= cfg_data;
			end
			// The output register fills on an emit and empties when the receiver takes it.
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						byte_q  <= in_byte;
						state_q <= S_DECODE;
						// A new stream restarts the parser, counters and window position before its first byte decodes.
						if (new_stream) begin
							phase_q    <= lzss_pkg::PH_FLAG;
							ctrl_q     <= 8'd0;
							bits_q     <= 4'd0;
							pend_q     <= 8'd0;
							emitted_q  <= 32'd0;
							finished_q <= 1'b0;
							wpos_q     <= lzss_pkg::START_POS;
							fill_q     <= '0;
						end
					end
				end
				S_DECODE: begin
					state_q <= S_IDLE;
					if (!finished_q) begin
						case (phase_q)
							lzss_pkg::PH_ITEM: begin
								if (ctrl_q[0]) begin
									lit_q   <= 1'b1;
									state_q <= S_EMIT;
								end else begin
									pend_q  <= byte_q;
									phase_q <= lzss_pkg::PH_MATCH_HI;
								end
							end
							lzss_pkg::PH_MATCH_HI: begin
								lit_q      <= 1'b0;
								src_q      <= {byte_q[7:4], pend_q};
								len_left_q <= {1'b0, byte_q[3:0]} + lzss_pkg::MATCH_EXTRA;
								state_q    <= S_READ;
							end
							default: begin
								ctrl_q  <= byte_q;
								bits_q  <= lzss_pkg::FLAG_BITS;
								phase_q <= lzss_pkg::PH_ITEM;
							end
						endcase
					end
				end
				S_READ: begin
					src_valid_q <= src_written;
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_byte_q  <= emit_data;
						out_last_q  <= emit_last;
						out_done_q  <= emit_done;
						emitted_q   <= emit_cnt;
						if (emit_done) begin
							finished_q <= 1'b1;
						end else begin
							wpos_q <= wpos_q + 1'b1;
							if (fill_q != (lzss_pkg::WIN_AW+1)'(lzss_pkg::WINDOW_BYTES)) begin
								fill_q <= fill_q + 1'b1;
							end
						end
						if (emit_last) begin
							ctrl_q  <= {1'b0, ctrl_q[7:1]};
							bits_q  <= bits_next;
							phase_q <= (bits_next == 4'd0) ? lzss_pkg::PH_FLAG
								: lzss_pkg::PH_ITEM;
							state_q <= S_IDLE;
						end else begin
							src_q      <= src_q + 1'b1;
							len_left_q <= len_left_q - 5'd1;
							state_q    <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;
	assign stream_done = out_done_q;

	// The end of the stream always closes the run of bytes for its request.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> last_of_run)
		else $error("stream end without last_of_run");

	// The fill count never passes the window size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (lzss_pkg::WIN_AW+1)'(lzss_pkg::WINDOW_BYTES))
		else $error("fill count beyond window");

	// No byte is produced once the stream has ended.
	a_no_emit_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> !finished_q)
		else $error("emit after stream end");

	// An accepted request keeps the input side stalled while it is decoded.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after request");

endmodule
